@@ rtl/wht_pkg.sv @@
// ----------------------------------------------------------------------------
// wht_pkg: shared types and constants of the water heater thermostat
// Request codes, register indexes, reset values and block-average constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wht_pkg;

	// Request kinds carried in the slave-side tuser.
	typedef enum logic [2:0] {
		REQ_SAMPLE = 3'd0,
		REQ_POWER  = 3'd1,
		REQ_UP     = 3'd2,
		REQ_DOWN   = 3'd3,
		REQ_SETTLE = 3'd4
	} req_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_BAND    = 2'd0,
		CFG_STEP    = 2'd1,
		CFG_SP_LOW  = 2'd2,
		CFG_SP_HIGH = 2'd3
	} cfg_idx_t;

	localparam int REQ_W   = 3;
	localparam int ADC_W   = 10;
	localparam int TEMP_W  = 8;
	localparam int BAND_W  = 5;
	localparam int STEP_W  = 5;
	localparam int SP_W    = 8;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 2;
	localparam int SUM_W   = 12;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Samples per averaging block.
	localparam int BLOCK_LEN = 10;
	localparam int CNT_W     = $clog2(BLOCK_LEN + 1);

	// sum / BLOCK_LEN as (sum * RECIP) >> RECIP_SHIFT; exact for every SUM_W-bit sum.
	localparam int RECIP_SHIFT = SUM_W + 5;
	localparam int RECIP       = (2 ** RECIP_SHIFT + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int RECIP_W     = RECIP_SHIFT;
	localparam int QPROD_W     = SUM_W + RECIP_W;

	// Degrees = floor(adc * 5000 / 1024 / 10) = floor(adc * 125 / 256).
	localparam int CONV_MUL   = 125;
	localparam int CONV_MUL_W = 7;
	localparam int CONV_SHIFT = 8;
	localparam int CONV_P_W   = ADC_W + CONV_MUL_W;

	localparam logic [BAND_W-1:0] BAND_RST    = BAND_W'(5);
	localparam logic [STEP_W-1:0] STEP_RST    = STEP_W'(5);
	localparam logic [SP_W-1:0]   SP_LOW_RST  = SP_W'(35);
	localparam logic [SP_W-1:0]   SP_HIGH_RST = SP_W'(75);
	localparam logic [SP_W-1:0]   TARGET_RST  = SP_W'(60);
	localparam logic [SP_W-1:0]   SP_MAX      = '1;

endpackage

`default_nettype wire

@@ rtl/water_heater_thermostat_core.sv @@
// ----------------------------------------------------------------------------
// water_heater_thermostat_core: bang-bang thermostat with block averaging
// Takes sample and button events, keeps the control state, reports it.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side stream carries one event per transfer: tuser holds the
//   request kind (sample, power, up, down, settle) and tdata the 10-bit
//   converter reading. Every accepted event produces exactly one transfer on
//   the master-side stream, which reports the last temperature, heater and
//   cooler drives, power state, setpoint and the set-mode flag as they stand
//   after that event.
//   An input transfer passes two registers before its result shows on
//   m_tvalid: the input register (where the reading is also converted to
//   degrees) and the state update registers, which are the result.
//   Throughput is one event per cycle unless the receiver stalls, set by
//   the state update loop (block sum add, reciprocal multiply, band compares).
//   When the receiver stalls, the result holds and one more event is taken
//   into the input register; s_tready then drops until the result leaves.
//   Reset clears both valid flags, turns the block off, disarms set mode,
//   zeroes the block sum, count and drives, loads the setpoint with 60 and
//   the configuration registers with their default values. Configuration
//   writes are meant for idle periods and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module water_heater_thermostat_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Slave side. tdata: adc_sample[9:0], zeros above. tuser: req_type[2:0].
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [wht_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic [wht_pkg::REQ_W-1:0]      s_tuser,
	// Master side. tdata: water_temp[7:0], heater_on[8], cooler_on[9],
	// powered[10], setpoint[18:11], set_armed[19], zeros above.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [wht_pkg::OUT_DATA_W-1:0]      m_tdata,
	// Configuration write port.
	input  wire logic                           cfg_wen,
	input  wire logic [wht_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [wht_pkg::CFG_W-1:0]      cfg_wdata
);
	import wht_pkg::*;

	// Configuration registers.
	logic [BAND_W-1:0] band_q;
	logic [STEP_W-1:0] step_q;
	logic [SP_W-1:0]   sp_low_q;
	logic [SP_W-1:0]   sp_high_q;

	// Input register: request kind and the reading already in degrees.
	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [TEMP_W-1:0] temp_s1;

	// Control state; these registers also form the result register.
	logic              out_valid_q;
	logic              power_q;
	logic              armed_q;
	logic [SP_W-1:0]   target_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [TEMP_W-1:0] temp_q;
	logic              heater_q;
	logic              cooler_q;

	logic                out_room;
	logic                adv;
	logic                in_xfer;
	logic [CONV_P_W-1:0] conv_prod;

	// Next-state values for one event.
	logic              power_d;
	logic              armed_d;
	logic [SP_W-1:0]   target_d;
	logic [SUM_W-1:0]  sum_d;
	logic [CNT_W-1:0]  count_d;
	logic [TEMP_W-1:0] temp_d;
	logic              heater_d;
	logic              cooler_d;

	logic [SUM_W-1:0]   sum_add;
	logic [CNT_W-1:0]   count_add;
	logic [QPROD_W-1:0] q_prod;
	logic [TEMP_W-1:0]  avg;
	logic signed [SP_W:0] diff_hot;
	logic signed [SP_W:0] diff_cold;
	logic signed [SP_W:0] band_s;
	logic [SP_W:0]      target_up;

	// Handshake: the input register moves on whenever the result register
	// is empty or being emptied in this cycle.
	assign out_room = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_room;
	assign s_tready = !valid_s1 || adv;
	assign in_xfer  = s_tvalid && s_tready;

	assign conv_prod = CONV_P_W'(s_tdata[ADC_W-1:0]) * CONV_P_W'(CONV_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1  <= s_tuser;
			temp_s1 <= conv_prod[CONV_SHIFT +: TEMP_W];
		end
	end

	// Block sum and average; the division by the block length is a
	// reciprocal multiply that is exact over the whole sum range.
	assign sum_add   = sum_q + SUM_W'(temp_s1);
	assign count_add = count_q + CNT_W'(1);
	assign q_prod    = QPROD_W'(sum_add) * QPROD_W'(RECIP);
	assign avg       = q_prod[RECIP_SHIFT +: TEMP_W];
	assign diff_hot  = $signed({1'b0, avg}) - $signed({1'b0, target_q});
	assign diff_cold = $signed({1'b0, target_q}) - $signed({1'b0, avg});
	assign band_s    = $signed((SP_W + 1)'(band_q));
	assign target_up = {1'b0, target_q} + (SP_W + 1)'(step_q);

	always_comb begin
		power_d  = power_q;
		armed_d  = armed_q;
		target_d = target_q;
		sum_d    = sum_q;
		count_d  = count_q;
		temp_d   = temp_q;
		heater_d = heater_q;
		cooler_d = cooler_q;
		unique case (req_t'(req_s1))
			REQ_SAMPLE: begin
				if (power_q) begin
					temp_d  = temp_s1;
					sum_d   = sum_add;
					count_d = count_add;
					if (count_add >= CNT_W'(BLOCK_LEN)) begin
						sum_d   = '0;
						count_d = '0;
						if (diff_hot >= band_s) begin
							cooler_d = 1'b1;
							heater_d = 1'b0;
						end else if (diff_cold >= band_s) begin
							heater_d = 1'b1;
							cooler_d = 1'b0;
						end else begin
							heater_d = 1'b0;
							cooler_d = 1'b0;
						end
					end
				end
			end
			REQ_POWER: begin
				power_d = !power_q;
			end
			REQ_UP: begin
				if (!armed_q) begin
					armed_d = 1'b1;
				end else if (power_q && (target_q < sp_high_q)) begin
					target_d = target_up[SP_W] ? SP_MAX : target_up[SP_W-1:0];
					armed_d  = 1'b0;
				end
			end
			REQ_DOWN: begin
				if (!armed_q) begin
					armed_d = 1'b1;
				end else if (power_q && (target_q > sp_low_q)) begin
					target_d = (target_q > SP_W'(step_q)) ? target_q - SP_W'(step_q) : '0;
					armed_d  = 1'b0;
				end
			end
			REQ_SETTLE: begin
				if (power_q) begin
					armed_d = 1'b0;
				end
			end
			default: begin
				// Unused request kinds leave the state as it is.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			power_q     <= 1'b0;
			armed_q     <= 1'b0;
			target_q    <= TARGET_RST;
			sum_q       <= '0;
			count_q     <= '0;
			temp_q      <= '0;
			heater_q    <= 1'b0;
			cooler_q    <= 1'b0;
		end else begin
			if (out_room) begin
				out_valid_q <= valid_s1;
			end
			if (adv) begin
				power_q  <= power_d;
				armed_q  <= armed_d;
				target_q <= target_d;
				sum_q    <= sum_d;
				count_q  <= count_d;
				temp_q   <= temp_d;
				heater_q <= heater_d;
				cooler_q <= cooler_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q    <= BAND_RST;
			step_q    <= STEP_RST;
			sp_low_q  <= SP_LOW_RST;
			sp_high_q <= SP_HIGH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BAND:    band_q    <= cfg_wdata[BAND_W-1:0];
				CFG_STEP:    step_q    <= cfg_wdata[STEP_W-1:0];
				CFG_SP_LOW:  sp_low_q  <= cfg_wdata[SP_W-1:0];
				CFG_SP_HIGH: sp_high_q <= cfg_wdata[SP_W-1:0];
				default:     band_q    <= band_q;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, armed_q, target_q, power_q, cooler_q, heater_q, temp_q};

	// The block count is cleared as soon as it reaches the block length.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(BLOCK_LEN))
		else $error("block count reached the block length");

	// Heater and cooler are never driven together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(heater_q && cooler_q))
		else $error("heater and cooler both on");

	// A held event in the input register does not change while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1) && $stable(temp_s1))
		else $error("waiting event changed");

	// A sample taken while off leaves the block sum and count alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && !power_q && (req_s1 == REQ_SAMPLE) |=> $stable(sum_q) && $stable(count_q))
		else $error("sample while off changed the block");

	// A result leaves the state registers untouched unless an event advances.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(target_q) && $stable(power_q) && $stable(armed_q))
		else $error("state changed without an event");

endmodule

`default_nettype wire

@@ tb/wht_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wht_tb_pkg: expected-state tracker for the thermostat testbench
// Mirrors the thermostat state and configuration. It queues the report
// that each accepted event should produce and compares the reports that
// the block returns.
// ----------------------------------------------------------------------------

package wht_tb_pkg;

	import wht_pkg::*;

	// Layout of the master-side tdata, highest field first.
	typedef struct packed {
		logic [3:0]        pad;
		logic              armed;
		logic [SP_W-1:0]   setpoint;
		logic              powered;
		logic              cooler;
		logic              heater;
		logic [TEMP_W-1:0] temp;
	} report_t;

	// Request codes that the block must ignore.
	localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
	localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

	class thermostat_tracker;

		localparam int ADC_FULL_MV = 5000;
		localparam int ADC_COUNTS  = 1024;
		localparam int MV_PER_DEG  = 10;
		localparam int DEG_MAX     = 255;

		logic [BAND_W-1:0] band    = BAND_RST;
		logic [STEP_W-1:0] step    = STEP_RST;
		logic [SP_W-1:0]   sp_low  = SP_LOW_RST;
		logic [SP_W-1:0]   sp_high = SP_HIGH_RST;

		logic              powered     = 1'b0;
		logic              armed       = 1'b0;
		logic [SP_W-1:0]   target      = TARGET_RST;
		logic [SUM_W-1:0]  block_sum   = '0;
		logic [3:0]        block_count = '0;
		logic [TEMP_W-1:0] last_temp   = '0;
		logic              heater      = 1'b0;
		logic              cooler      = 1'b0;

		report_t pending[$];
		int errors     = 0;
		int n_events   = 0;
		int n_reports  = 0;
		int n_blocks   = 0;
		int n_heat     = 0;
		int n_cool     = 0;
		int n_sat      = 0;

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_BAND:    band    = value[BAND_W-1:0];
				CFG_STEP:    step    = value[STEP_W-1:0];
				CFG_SP_LOW:  sp_low  = value;
				CFG_SP_HIGH: sp_high = value;
				default: ;
			endcase
		endfunction

		function void take_sample(logic [ADC_W-1:0] adc);
			int deg;
			int avg;
			if (!powered)
				return;
			deg = ((int'(adc) * ADC_FULL_MV) / ADC_COUNTS) / MV_PER_DEG;
			last_temp = deg[TEMP_W-1:0];
			block_sum = block_sum + last_temp;
			block_count = block_count + 4'd1;
			if (block_count >= BLOCK_LEN) begin
				avg = int'(block_sum / BLOCK_LEN) & DEG_MAX;
				block_sum = '0;
				block_count = '0;
				n_blocks++;
				if (avg - int'(target) >= int'(band)) begin
					cooler = 1'b1;
					heater = 1'b0;
					n_cool++;
				end else if (int'(target) - avg >= int'(band)) begin
					heater = 1'b1;
					cooler = 1'b0;
					n_heat++;
				end else begin
					heater = 1'b0;
					cooler = 1'b0;
				end
			end
		endfunction

		// The first press only arms set mode; a later one steps while powered.
		function void press(bit up);
			int moved;
			if (!armed) begin
				armed = 1'b1;
				return;
			end
			if (!powered)
				return;
			if (up) begin
				if (target < sp_high) begin
					moved = int'(target) + int'(step);
					if (moved > DEG_MAX) begin
						moved = DEG_MAX;
						n_sat++;
					end
					target = moved[SP_W-1:0];
					armed = 1'b0;
				end
			end else if (target > sp_low) begin
				if (target > step) begin
					target = target - step;
				end else begin
					target = '0;
					n_sat++;
				end
				armed = 1'b0;
			end
		endfunction

		function void note_event(logic [REQ_W-1:0] kind, logic [ADC_W-1:0] adc);
			report_t r;
			n_events++;
			case (kind)
				REQ_SAMPLE: take_sample(adc);
				REQ_POWER:  powered = !powered;
				REQ_UP:     press(1'b1);
				REQ_DOWN:   press(1'b0);
				REQ_SETTLE: if (powered) armed = 1'b0;
				default: ;
			endcase
			r = '0;
			r.temp     = last_temp;
			r.heater   = heater;
			r.cooler   = cooler;
			r.powered  = powered;
			r.setpoint = target;
			r.armed    = armed;
			pending.push_back(r);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: report %h arrived with none expected", $time, got);
				return;
			end
			want = pending.pop_front();
			n_reports++;
			compare_field("water_temp", want.temp, got.temp);
			compare_field("heater_on", 8'(want.heater), 8'(got.heater));
			compare_field("cooler_on", 8'(want.cooler), 8'(got.cooler));
			compare_field("powered", 8'(want.powered), 8'(got.powered));
			compare_field("setpoint", want.setpoint, got.setpoint);
			compare_field("set_armed", 8'(want.armed), 8'(got.armed));
			compare_field("tdata padding", 8'(want.pad), 8'(got.pad));
		endfunction

	endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of water_heater_thermostat_core
// Drives sample and button events on the input stream, tracks the expected
// thermostat state and checks every report on the output stream. Register
// settings change between phases that differ in how often the sender idles
// and the receiver stalls.
// ----------------------------------------------------------------------------

module tb_top;

	import wht_pkg::*;
	import wht_tb_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 7;
	// Longest quiet stretch is the forced receiver hold-off plus a few random
	// stalls; this limit leaves a wide margin over that.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 64;
	// Slack after the last report drains, before registers change.
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_EVENTS   = 235;
	localparam int WALK_PRESSES   = 28;
	localparam int DEG_TOP        = 499;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [REQ_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wen;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	// The main process bumps hold_seq; the receiver then holds off on its own.
	int hold_seq       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	// Offset of the sample temperatures from the setpoint, redrawn per block.
	int temp_bias      = 0;
	int settings_used  = 1;

	thermostat_tracker tracker = new();

	water_heater_thermostat_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Receiver: stalls at random, or holds off for a long stretch on request
	// so that the result and input registers both fill and s_tready drops.
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Every input transfer queues the report it should produce.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.note_event(s_tuser, s_tdata[ADC_W-1:0]);
	end

	// Every output transfer is checked against the oldest queued report.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_report(report_t'(m_tdata));
	end

	// Ends the run if neither stream moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** water_heater_thermostat_core: FAILED **");
		$finish;
	end

	// Offers one event, idling first as the phase asks, and returns at the
	// falling edge after the transfer. Entered and left at a falling edge.
	task automatic send_event(input logic [REQ_W-1:0] kind, input logic [ADC_W-1:0] adc);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {{(IN_DATA_W-ADC_W){1'b0}}, adc};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Writes all four registers on consecutive cycles; only called while idle.
	task automatic write_settings(input int band, input int step, input int lo, input int hi);
		logic [CFG_W-1:0] value [4];
		value[0] = CFG_W'(band);
		value[1] = CFG_W'(step);
		value[2] = CFG_W'(lo);
		value[3] = CFG_W'(hi);
		cfg_wen = 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index = cfg_idx_t'(i);
			cfg_wdata = value[i];
			tracker.write_reg(cfg_idx_t'(i), value[i]);
			@(negedge clk);
		end
		cfg_wen = 1'b0;
		settings_used = settings_used + 1;
	endtask

	// Lets every queued report drain, then a few more cycles.
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed traffic: the block kept on, samples whose block
	// averages fall near the setpoint, presses in arm-then-step pairs.
	// The rest is single presses, power toggles, settles and unused codes.
	task automatic send_random_event();
		int roll;
		int goal;
		int adc;
		logic [REQ_W-1:0] press_kind;
		roll = int'($urandom_range(0, 99));
		press_kind = $urandom_range(0, 1) ? REQ_UP : REQ_DOWN;
		if (!tracker.powered && roll < 80) begin
			send_event(REQ_POWER, ADC_W'($urandom));
		end else if (roll < 66) begin
			if (tracker.block_count == 0)
				temp_bias = int'($urandom_range(0, 50)) - 25;
			if ($urandom_range(0, 99) < 85) begin
				goal = int'(tracker.target) + temp_bias + int'($urandom_range(0, 20)) - 10;
				if (goal < 0)
					goal = 0;
				if (goal > DEG_TOP)
					goal = DEG_TOP;
				// Smallest reading that converts to goal, sometimes one above.
				adc = (goal * 256 + 124) / 125 + int'($urandom_range(0, 1));
				if (adc > 1023)
					adc = 1023;
			end else begin
				adc = int'($urandom_range(0, 1023));
			end
			send_event(REQ_SAMPLE, ADC_W'(adc));
		end else if (roll < 78) begin
			send_event(press_kind, ADC_W'($urandom));
			send_event(press_kind, ADC_W'($urandom));
		end else if (roll < 84) begin
			send_event(press_kind, ADC_W'($urandom));
		end else if (roll < 90) begin
			send_event(REQ_SETTLE, ADC_W'($urandom));
		end else if (roll < 95) begin
			send_event(REQ_POWER, ADC_W'($urandom));
		end else begin
			send_event(REQ_T_UNUSED(), ADC_W'($urandom));
		end
	endtask

	function automatic logic [REQ_W-1:0] REQ_T_UNUSED();
		return REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
	endfunction

	// One phase: new registers, new idle pattern, then random traffic. The
	// optional walk drives the setpoint into both saturation limits and
	// then forces a long receiver hold-off while the sender keeps going.
	task automatic run_phase(input int src_pct, input int sink_pct, input int band,
				 input int step, input int lo, input int hi, input bit with_walk);
		write_settings(band, step, lo, hi);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		if (with_walk) begin
			if (!tracker.powered)
				send_event(REQ_POWER, '0);
			send_event(REQ_SETTLE, '0);
			repeat (WALK_PRESSES) send_event(REQ_UP, ADC_W'($urandom));
			send_event(REQ_SETTLE, '0);
			repeat (WALK_PRESSES) send_event(REQ_DOWN, ADC_W'($urandom));
			hold_seq = hold_seq + 1;
		end
		repeat (PHASE_EVENTS) send_random_event();
		wait_idle();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_SAMPLE;
		cfg_wen   = 1'b0;
		cfg_index = CFG_BAND;
		cfg_wdata = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed events at the reset settings. While off, a sample is
		// ignored, a press still arms set mode, a second press does not
		// step, and a settle leaves set mode armed.
		send_event(REQ_SAMPLE, 10'h3FF);
		send_event(REQ_UP, '0);
		send_event(REQ_DOWN, '0);
		send_event(REQ_SETTLE, '0);
		// Powered: a settle disarms; unused codes change nothing.
		send_event(REQ_POWER, '0);
		send_event(REQ_SETTLE, '0);
		for (int k = REQ_FIRST_UNUSED; k <= REQ_LAST_UNUSED; k++)
			send_event(REQ_W'(k), 10'h2AA);
		// One full block of the extreme readings: the average lies far
		// above the setpoint, so the cooler switches on.
		repeat (5) begin
			send_event(REQ_SAMPLE, 10'h3FF);
			send_event(REQ_SAMPLE, 10'h000);
		end
		// Arm-then-step pairs in both directions.
		send_event(REQ_UP, '0);
		send_event(REQ_UP, '0);
		send_event(REQ_DOWN, '0);
		send_event(REQ_DOWN, '0);
		// Power off keeps the drives and the partial block; samples are
		// ignored until power returns.
		send_event(REQ_POWER, '0);
		send_event(REQ_SAMPLE, 10'h155);
		send_event(REQ_POWER, '0);
		wait_idle();

		run_phase(0, 0, 1, 20, 0, 255, 1'b1);
		run_phase(75, 0, 20, 1, 255, 0, 1'b0);
		run_phase(0, 75, 3, 7, 40, 200, 1'b0);
		run_phase(11, 11, int'($urandom_range(1, 20)), int'($urandom_range(1, 20)),
			  int'($urandom_range(0, 255)), int'($urandom_range(0, 255)), 1'b0);

		$display("Sent %0d events under %0d register settings, %0d reports checked.",
			 tracker.n_events, settings_used, tracker.n_reports);
		$display("Closed %0d averaging blocks (%0d heating, %0d cooling), %0d setpoint clamps.",
			 tracker.n_blocks, tracker.n_heat, tracker.n_cool, tracker.n_sat);
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("** water_heater_thermostat_core: PASSED **");
		else
			$display("** water_heater_thermostat_core: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/wht_pkg.sv
rtl/water_heater_thermostat_core.sv
tb/wht_tb_pkg.sv
tb/tb_top.sv
